// ===== design/scwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwm_pkg: shared types and constants of the clipped window mean core
// Field widths, register indexes and reset values, controller states and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package scwm_pkg;

   // Fixed field widths.
   localparam int SAMPLE_W   = 10;
   localparam int OFFSET_W   = 10;
   localparam int GAIN_W     = 16;
   localparam int MEAN_W     = 18;
   localparam int PRESS_W    = 19;
   localparam int KEPT_W     = 9;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Q8    = 1'b1;

   // Register reset values.
   localparam logic [OFFSET_W-1:0] RAW_OFFSET_RESET = 10'd191;
   localparam logic [GAIN_W-1:0]   GAIN_Q8_RESET    = 16'd1954;

   // Controller states.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SUM    = 7'b0000010,
      ST_VAR    = 7'b0000100,
      ST_KEEP   = 7'b0001000,
      ST_DLOAD  = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   // Which accumulation a pass over the window feeds.
   typedef enum logic [1:0] {
      PASS_NONE = 2'd0,
      PASS_SUM  = 2'd1,
      PASS_VAR  = 2'd2,
      PASS_KEEP = 2'd3
   } pass_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic     wr_en;
      logic     rd_en;
      pass_type op;
      logic     clear;
      logic     div_load;
      logic     div_step;
      logic     mul_en;
      logic     load_out;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic pipe_busy;
      logic d_zero;
   } status_type;

endpackage

// ===== design/sigma_clipped_window_mean_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigma_clipped_window_mean_core: sliding window mean with one-sigma clipping
// Keeps the last WINDOW samples, averages those within one standard
// deviation of the window mean and scales the mean to a pressure.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on req_valid / req_sample; req_stall is high while an
//   item is in work. A beat is taken when req_valid is high and req_stall low.
//   The first WINDOW beats after reset only fill the window and give no result;
//   each later beat gives one result beat on the rsp_ channel.
//   For a result, the core runs three passes over the window memory (sum,
//   squared deviation, clipping), a divider load, a bit-serial mean divider
//   that gives one quotient bit per cycle, the pressure multiply and the
//   output register load. The next sample is taken in the cycle after that
//   load at the earliest. A flat window skips the clipping pass.
//   A finished result waits in the output register while rsp_stall is high;
//   the next sample is accepted and worked on meanwhile, and its result waits
//   until the earlier beat is taken. Reset clears the window fill level, the
//   write pointer and any pending result, and sets raw_offset to 191 and
//   gain_q8 to 1954. Registers are to be written by the user, only while idle,
//   via csr_write_enable / csr_index / csr_write_data; the core does not check.
// ----------------------------------------------------------------------------
module sigma_clipped_window_mean_core #(
   parameter int WINDOW = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [scwm_pkg::SAMPLE_W-1:0]         req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [scwm_pkg::MEAN_W-1:0]           rsp_filtered_mean_q8,
   output logic signed [scwm_pkg::PRESS_W-1:0]   rsp_pressure,
   output logic [scwm_pkg::KEPT_W-1:0]           rsp_kept_count,
   output logic                                  rsp_flat_window,
   input  logic                                  csr_write_enable,
   input  logic [scwm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [scwm_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import scwm_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);

   cmd_type           cmd;
   status_type        status;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_addr;

   // Sequencer.
   scwm_controller #(
      .WINDOW (WINDOW)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   // Window memory and arithmetic.
   scwm_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .wr_addr          (wr_addr),
      .rd_addr          (rd_addr),
      .sample           (req_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .filtered_mean_q8 (rsp_filtered_mean_q8),
      .pressure         (rsp_pressure),
      .kept_count       (rsp_kept_count),
      .flat_window      (rsp_flat_window)
   );

endmodule

// ===== design/scwm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwm_datapath: window memory, statistics pipeline, divider and scaling
// Holds the sample window, runs the sum, deviation and clipping passes, the
// bit-serial mean divider, the pressure multiply and the result registers.
// ----------------------------------------------------------------------------
module scwm_datapath #(
   parameter int WINDOW = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  scwm_pkg::cmd_type                     cmd,
   input  logic [$clog2(WINDOW)-1:0]             wr_addr,
   input  logic [$clog2(WINDOW)-1:0]             rd_addr,
   input  logic [scwm_pkg::SAMPLE_W-1:0]         sample,
   input  logic                                  csr_write_enable,
   input  logic [scwm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [scwm_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output scwm_pkg::status_type                  status,
   output logic [scwm_pkg::MEAN_W-1:0]           filtered_mean_q8,
   output logic signed [scwm_pkg::PRESS_W-1:0]   pressure,
   output logic [scwm_pkg::KEPT_W-1:0]           kept_count,
   output logic                                  flat_window
);
   import scwm_pkg::*;

   localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SQ_W  = 2 * SUM_W;
   localparam int D_W   = 2 * SUM_W + $clog2(WINDOW);
   localparam int NUM_W = SUM_W + 8;
   localparam int PROD_W = PRESS_W + GAIN_W + 1;

   // Configuration registers.
   logic [OFFSET_W-1:0] raw_offset_ff;
   logic [GAIN_W-1:0]   gain_q8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_offset_ff <= RAW_OFFSET_RESET;
         gain_q8_ff    <= GAIN_Q8_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RAW_OFFSET: raw_offset_ff <= csr_write_data[OFFSET_W-1:0];
            CSR_GAIN_Q8:    gain_q8_ff    <= csr_write_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Window memory with a registered read port.
   logic [SAMPLE_W-1:0] mem [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= sample;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Stage valid flags of the pass pipeline.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Accumulators and pipeline payload.
   logic [SUM_W-1:0]          sum_ff;
   logic [D_W-1:0]            d_ff;
   logic [SUM_W-1:0]          ks_ff;
   logic [CNT_W-1:0]          kept_ff;
   logic signed [SUM_W:0]     diff_ff;
   logic [SAMPLE_W-1:0]       x2_ff, x3_ff, x4_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic [D_W-1:0]            wsq_ff;

   logic [SUM_W-1:0]          nx;
   logic signed [SUM_W:0]     diff_in;
   logic signed [SQ_W+1:0]    sq_full;

   // Deviation N*x - S of the sample leaving the memory.
   assign nx      = SUM_W'(WINDOW) * SUM_W'(rd_data_ff);
   assign diff_in = $signed({1'b0, nx}) - $signed({1'b0, sum_ff});
   assign sq_full = diff_ff * diff_ff;

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      x2_ff   <= rd_data_ff;
      sq_ff   <= sq_full[SQ_W-1:0];
      x3_ff   <= x2_ff;
      wsq_ff  <= D_W'(sq_ff) * D_W'(WINDOW - 1);
      x4_ff   <= x3_ff;
   end

   // Sum, squared deviation and clipped sum accumulation.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         sum_ff  <= '0;
         d_ff    <= '0;
         ks_ff   <= '0;
         kept_ff <= '0;
      end else begin
         if (s1_valid_ff && cmd.op == PASS_SUM) begin
            sum_ff <= sum_ff + SUM_W'(rd_data_ff);
         end
         if (s3_valid_ff && cmd.op == PASS_VAR) begin
            d_ff <= d_ff + D_W'(sq_ff);
         end
         if (s4_valid_ff && cmd.op == PASS_KEEP && wsq_ff < d_ff) begin
            ks_ff   <= ks_ff + SUM_W'(x4_ff);
            kept_ff <= kept_ff + 1'b1;
         end
      end
   end

   assign status.pipe_busy = s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff;
   assign status.d_zero    = (d_ff == '0);

   // Restoring divider: one quotient bit per step, quotient shifts into num_ff.
   logic [NUM_W-1:0] num_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W-1:0] div_ff;
   logic             flat_ff;
   logic             use_all;
   logic [CNT_W:0]   trial;
   logic             q_bit;

   assign use_all = (d_ff == '0) || (kept_ff == '0);
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit   = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff  <= {(use_all ? sum_ff : ks_ff), 8'd0};
         div_ff  <= use_all ? CNT_W'(WINDOW) : kept_ff;
         rem_ff  <= '0;
         flat_ff <= (d_ff == '0);
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], q_bit};
      end
   end

   // Pressure scaling: (mean - offset * 256) * gain, floored by the shift.
   logic signed [PRESS_W-1:0] pdiff;
   logic signed [GAIN_W:0]    gain_s;
   logic signed [PROD_W-1:0]  prod_ff;

   assign pdiff  = $signed({1'b0, num_ff[MEAN_W-1:0]})
                 - $signed({1'b0, raw_offset_ff, 8'd0});
   assign gain_s = $signed({1'b0, gain_q8_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= pdiff * gain_s;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         filtered_mean_q8 <= num_ff[MEAN_W-1:0];
         pressure         <= prod_ff[PRESS_W+15:16];
         kept_count       <= KEPT_W'(div_ff);
         flat_window      <= flat_ff;
      end
   end

endmodule

// ===== design/scwm_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwm_controller: sequencer of the clipped window mean core
// Accepts samples, tracks the write pointer and fill level, steps the
// datapath through its passes and the divider, and owns the result valid.
// ----------------------------------------------------------------------------
module scwm_controller #(
   parameter int WINDOW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  scwm_pkg::status_type          status,
   output scwm_pkg::cmd_type             cmd,
   output logic [$clog2(WINDOW)-1:0]     wr_addr,
   output logic [$clog2(WINDOW)-1:0]     rd_addr
);
   import scwm_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = $clog2(WINDOW * 1023 + 1);
   localparam int NUM_W  = SUM_W + 8;
   localparam int CTR_MAX = (WINDOW > NUM_W) ? WINDOW : NUM_W;
   localparam int CTR_W  = $clog2(CTR_MAX + 1);

   state_type           state_ff, state_in;
   logic [CTR_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]    wp_ff, wp_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                issuing;
   logic                out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign issuing   = (cnt_ff < CTR_W'(WINDOW));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign wr_addr   = wp_ff;
   assign rd_addr   = cnt_ff[IDX_W-1:0];

   // Next state, counters and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      cmd          = '0;
      cmd.op       = PASS_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            cmd.clear  = 1'b1;
            cmd.wr_en  = accept;
            if (accept) begin
               wp_in = (wp_ff == IDX_W'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
               if (fill_ff < FILL_W'(WINDOW)) begin
                  fill_in = fill_ff + 1'b1;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM, ST_VAR, ST_KEEP: begin
            cmd.op = (state_ff == ST_SUM) ? PASS_SUM :
                     (state_ff == ST_VAR) ? PASS_VAR : PASS_KEEP;
            if (issuing) begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end else if (!status.pipe_busy) begin
               cnt_in = '0;
               case (state_ff)
                  ST_SUM:  state_in = ST_VAR;
                  ST_VAR:  state_in = status.d_zero ? ST_DLOAD : ST_KEEP;
                  default: state_in = ST_DLOAD;
               endcase
            end
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CTR_W'(NUM_W - 1)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // The product is captured in the first cycle here; the result loads
            // once the output register is free.
            cmd.mul_en = !cnt_ff[0];
            if (cnt_ff[0] && out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = CTR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
